// ===== rtl/blt_pkg.sv =====
// ----------------------------------------------------------------------------
// blt_pkg: shared constants and types for the 3x3 binary LUT transform
// Sizes of the line store, lookup table and counters, request codes and the
// structs passed between the stream controller and the line buffer.
// ----------------------------------------------------------------------------
package blt_pkg;

  // Sizing
  localparam int MAX_WIDTH   = 1024;
  localparam int LUT_ENTRIES = 512;
  localparam int HGT_LIMIT   = 1024;
  localparam int NUM_SLOTS   = 4;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int PND_W  = $clog2(MAX_WIDTH + 3);
  localparam int ROW_W  = $clog2(HGT_LIMIT);
  localparam int HGT_W  = $clog2(HGT_LIMIT + 1);
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int LUT_AW = $clog2(LUT_ENTRIES);

  // Fixed field widths
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 4;
  localparam int REQ_W     = 2;
  localparam int PIX_W     = 8;
  localparam int VAL_W     = 8;
  localparam int TIDX_W    = 9;
  localparam int WIN_W     = 9;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TABLE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PIXEL = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DRAIN = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 4'd1;

  // Pixel write into the line store
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [COL_W-1:0]  col;
    logic              px;
  } line_wr_t;

  // Window fetch: three row slots and three columns
  typedef struct packed {
    logic [SLOT_W-1:0] slot_prv;
    logic [SLOT_W-1:0] slot_cur;
    logic [SLOT_W-1:0] slot_nxt;
    logic [COL_W-1:0]  col_l;
    logic [COL_W-1:0]  col_m;
    logic [COL_W-1:0]  col_r;
  } win_req_t;

endpackage

// ===== rtl/blt_ram.sv =====
// ----------------------------------------------------------------------------
// blt_ram: generic single-write, single-read synchronous RAM
// One write port, one read port with enable; read data registered and
// returns the old contents on a same-address write.
// ----------------------------------------------------------------------------
module blt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/blt_ctrl.sv =====
// ----------------------------------------------------------------------------
// blt_ctrl: stream counters and window addressing
// Holds the geometry registers, input and output raster positions and the
// pending count; decides when an output is produced and where to fetch it.
// ----------------------------------------------------------------------------
module blt_ctrl import blt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 accept_i,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [PIX_W-1:0]     pixel_value_i,
  output line_wr_t             line_wr_o,
  output win_req_t             win_req_o,
  output logic                 emit_o,
  output logic                 last_o
);

  logic [WID_W-1:0]  eff_w_q, eff_w_d;
  logic [HGT_W-1:0]  eff_h_q, eff_h_d;
  logic [COL_W-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;
  logic [SLOT_W-1:0] in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic [PND_W-1:0]  pend_q, pend_d;

  logic [WID_W-1:0] w_m1;
  logic [HGT_W-1:0] h_m1;
  logic [31:0]      cfg_val;
  logic             is_pix, is_drain, clear;
  logic             in_eol, in_eoi, out_eol, out_eoi;

  assign w_m1    = eff_w_q - WID_W'(1);
  assign h_m1    = eff_h_q - HGT_W'(1);
  assign cfg_val = 32'(cfg_wdata_i);

  assign is_pix   = accept_i && (req_type_i == REQ_PIXEL);
  assign is_drain = accept_i && (req_type_i == REQ_DRAIN);
  assign clear    = cfg_we_i && ((cfg_index_i == REG_WIDTH) || (cfg_index_i == REG_HEIGHT));

  // output decision: steady state lag of width+1, or a drain
  assign emit_o = (is_pix && (pend_q > PND_W'(eff_w_q))) ||
                  (is_drain && (pend_q != '0));

  // raster position flags
  assign in_eol  = (WID_W'(in_col_q) == w_m1);
  assign in_eoi  = (HGT_W'(in_row_q) == h_m1);
  assign out_eol = (WID_W'(out_col_q) == w_m1);
  assign out_eoi = (HGT_W'(out_row_q) == h_m1);

  // pixel write into the current input slot
  assign line_wr_o.en   = is_pix;
  assign line_wr_o.slot = in_slot_q;
  assign line_wr_o.col  = in_col_q;
  assign line_wr_o.px   = (pixel_value_i != '0);

  // window addresses with edge replication
  always_comb begin
    win_req_o.col_m    = out_col_q;
    win_req_o.col_l    = (out_col_q == '0) ? '0 : out_col_q - COL_W'(1);
    win_req_o.col_r    = (WID_W'(out_col_q) < w_m1) ? out_col_q + COL_W'(1)
                                                    : COL_W'(w_m1);
    win_req_o.slot_cur = out_slot_q;
    win_req_o.slot_nxt = (HGT_W'(out_row_q) < h_m1) ? out_slot_q + SLOT_W'(1)
                                                    : out_slot_q;
    win_req_o.slot_prv = (out_row_q != '0) ? out_slot_q - SLOT_W'(1) : out_slot_q;
  end

  assign last_o = out_eol && out_eoi;

  // next-state logic
  always_comb begin
    eff_w_d    = eff_w_q;
    eff_h_d    = eff_h_q;
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_slot_d  = in_slot_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_slot_d = out_slot_q;
    pend_d     = pend_q;

    if (clear) begin
      if (cfg_index_i == REG_WIDTH) begin
        if (cfg_val < 32'd2) begin
          eff_w_d = WID_W'(2);
        end else if (cfg_val > 32'(MAX_WIDTH)) begin
          eff_w_d = WID_W'(MAX_WIDTH);
        end else begin
          eff_w_d = WID_W'(cfg_val);
        end
      end else begin
        if (cfg_val < 32'd2) begin
          eff_h_d = HGT_W'(2);
        end else if (cfg_val > 32'(HGT_LIMIT)) begin
          eff_h_d = HGT_W'(HGT_LIMIT);
        end else begin
          eff_h_d = HGT_W'(cfg_val);
        end
      end
      in_col_d   = '0;
      in_row_d   = '0;
      in_slot_d  = '0;
      out_col_d  = '0;
      out_row_d  = '0;
      out_slot_d = '0;
      pend_d     = '0;
    end else begin
      // input raster advance
      if (is_pix) begin
        if (in_eol) begin
          in_col_d  = '0;
          in_slot_d = in_slot_q + SLOT_W'(1);
          in_row_d  = in_eoi ? '0 : in_row_q + ROW_W'(1);
        end else begin
          in_col_d = in_col_q + COL_W'(1);
        end
      end
      // output raster advance
      if (emit_o) begin
        if (out_eol) begin
          out_col_d  = '0;
          out_slot_d = out_slot_q + SLOT_W'(1);
          out_row_d  = out_eoi ? '0 : out_row_q + ROW_W'(1);
        end else begin
          out_col_d = out_col_q + COL_W'(1);
        end
      end
      // pending count
      if (is_pix && !emit_o) begin
        pend_d = pend_q + PND_W'(1);
      end else if (is_drain && emit_o) begin
        pend_d = pend_q - PND_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q    <= WID_W'(MAX_WIDTH);
      eff_h_q    <= HGT_W'(HGT_LIMIT);
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
      pend_q     <= '0;
    end else begin
      eff_w_q    <= eff_w_d;
      eff_h_q    <= eff_h_d;
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_slot_q  <= in_slot_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_slot_q <= out_slot_d;
      pend_q     <= pend_d;
    end
  end

endmodule

// ===== rtl/blt_line_buf.sv =====
// ----------------------------------------------------------------------------
// blt_line_buf: four-row binary line store and window assembly
// Each row slot is kept in three RAM copies so the left, middle and right
// columns read in the same cycle. A write in the same cycle as the fetch is
// forwarded into the window.
// ----------------------------------------------------------------------------
module blt_line_buf import blt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  line_wr_t          wr_i,
  input  win_req_t          req_i,
  output logic [WIN_W-1:0]  idx_o
);

  localparam int NUM_TAPS = 3;

  logic     rd [NUM_SLOTS][NUM_TAPS];
  line_wr_t wr_q;
  win_req_t req_q;

  // slot x tap RAM array, all copies of one slot written together
  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_slot
    for (genvar j = 0; j < NUM_TAPS; j++) begin : g_tap
      logic [COL_W-1:0] raddr;
      logic             we;

      assign raddr = (j == 0) ? req_i.col_l : ((j == 1) ? req_i.col_m : req_i.col_r);
      assign we    = wr_i.en && (wr_i.slot == SLOT_W'(k));

      blt_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH)
      ) u_ram (
        .clk_i   (clk_i),
        .we_i    (we),
        .waddr_i (wr_i.col),
        .wdata_i (wr_i.px),
        .re_i    (en_i),
        .raddr_i (raddr),
        .rdata_o (rd[k][j])
      );
    end
  end

  // fetch context for the read data stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      req_q <= '0;
    end else if (en_i) begin
      wr_q  <= wr_i;
      req_q <= req_i;
    end
  end

  // one window bit: slot selection plus same-cycle write forwarding
  function automatic logic tap_bit(input logic rdv [NUM_SLOTS][NUM_TAPS],
                                   input line_wr_t wq,
                                   input logic [SLOT_W-1:0] slot,
                                   input int unsigned tap,
                                   input logic [COL_W-1:0] col);
    logic v;
    v = rdv[slot][tap];
    if (wq.en && (wq.slot == slot) && (wq.col == col)) begin
      v = wq.px;
    end
    return v;
  endfunction

  // window index packing
  always_comb begin
    idx_o[0] = tap_bit(rd, wr_q, req_q.slot_cur, 1, req_q.col_m);
    idx_o[1] = tap_bit(rd, wr_q, req_q.slot_cur, 2, req_q.col_r);
    idx_o[2] = tap_bit(rd, wr_q, req_q.slot_nxt, 2, req_q.col_r);
    idx_o[3] = tap_bit(rd, wr_q, req_q.slot_nxt, 1, req_q.col_m);
    idx_o[4] = tap_bit(rd, wr_q, req_q.slot_nxt, 0, req_q.col_l);
    idx_o[5] = tap_bit(rd, wr_q, req_q.slot_cur, 0, req_q.col_l);
    idx_o[6] = tap_bit(rd, wr_q, req_q.slot_prv, 0, req_q.col_l);
    idx_o[7] = tap_bit(rd, wr_q, req_q.slot_prv, 1, req_q.col_m);
    idx_o[8] = tap_bit(rd, wr_q, req_q.slot_prv, 2, req_q.col_r);
  end

endmodule

// ===== rtl/binary_3x3_lut_transform.sv =====
// ----------------------------------------------------------------------------
// binary_3x3_lut_transform: 3x3 binary neighborhood lookup over a pixel stream
//
// Input channel (in_valid_i / in_stall_o): one request per transfer, a table
// write, a pixel or a drain. Table writes load the 512-entry lookup table
// before pixels that use it arrive. Pixels come in raster order; each
// nonzero pixel counts as set. An output for a pixel is produced once width+1
// more pixels have arrived, or on a drain request for the oldest pending one.
// Output channel (out_valid_o / out_stall_i): the table byte selected by the
// pixel's 3x3 window, with out_last_o on the last pixel of an image.
// Configuration (cfg_valid_i / cfg_ready_o, always ready): register 0 is the
// image width, 1 the height; a write clears the stream counters and pending
// outputs but keeps the table. Write only while the block is idle.
// Throughput is one request per cycle unless stalled: the line store reads
// three columns of every row slot each cycle and the table one entry per
// pixel. A result reaches out_valid_o through the line store read, table
// read and output register. While the output is stalled the whole pipeline
// holds and in_stall_o is raised. Reset clears the counters and the output
// valid; line store and table contents are undefined until written.
// ----------------------------------------------------------------------------
module binary_3x3_lut_transform import blt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [TIDX_W-1:0]    table_index_i,
  input  logic [VAL_W-1:0]     table_value_i,
  input  logic [PIX_W-1:0]     pixel_value_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [VAL_W-1:0]     out_value_o,
  output logic                 out_last_o
);

  logic             en, accept, emit, last;
  line_wr_t         line_wr;
  win_req_t         win_req;
  logic [WIN_W-1:0] win_idx;
  logic [VAL_W-1:0] lut_rdata;
  logic             lut_we;
  logic             vld_b_q, vld_c_q, out_valid_q;
  logic             last_b_q, last_c_q, out_last_q;
  logic [VAL_W-1:0] out_value_q;

  // pipeline advance unless a result waits on a stalled receiver
  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign accept      = in_valid_i && en;
  assign cfg_ready_o = 1'b1;

  blt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .req_type_i    (req_type_i),
    .pixel_value_i (pixel_value_i),
    .line_wr_o     (line_wr),
    .win_req_o     (win_req),
    .emit_o        (emit),
    .last_o        (last)
  );

  blt_line_buf u_line_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .wr_i   (line_wr),
    .req_i  (win_req),
    .idx_o  (win_idx)
  );

  // lookup table
  assign lut_we = accept && (req_type_i == REQ_TABLE);

  blt_ram #(
    .WIDTH (VAL_W),
    .DEPTH (LUT_ENTRIES)
  ) u_lut (
    .clk_i   (clk_i),
    .we_i    (lut_we),
    .waddr_i (LUT_AW'(table_index_i)),
    .wdata_i (table_value_i),
    .re_i    (en),
    .raddr_i (LUT_AW'(win_idx)),
    .rdata_o (lut_rdata)
  );

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q     <= 1'b0;
      vld_c_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_b_q     <= emit;
      vld_c_q     <= vld_b_q;
      out_valid_q <= vld_c_q;
    end
  end

  // payload pipeline
  always_ff @(posedge clk_i) begin
    if (en) begin
      last_b_q    <= last;
      last_c_q    <= last_b_q;
      out_last_q  <= last_c_q;
      out_value_q <= lut_rdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

endmodule
